@@ hdl/line_follow_pd_steering_macros.svh @@
// Assertion macros shared by the line follower steering RTL.
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LFPS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LFPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lfps_pkg.sv @@
// Package with types, constants and register codes of the line follower steering block.
`timescale 1ns / 1ps

package lfps_pkg;

  localparam int SensorCountDef = 8;
  localparam int WeightW        = 8;
  localparam int SumW           = 11;
  localparam int CountW         = 4;

  // Shared divider: magnitude of up to 26 bits over a 16-bit divisor.
  localparam int DivNumW = 26;
  localparam int DivDenW = 16;

  // Configuration port.
  localparam int AddrW   = 6;
  localparam int DataW   = 64;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegSensorWeights = 3'd0;
  localparam logic [RegIdxW-1:0] RegPropGain      = 3'd1;
  localparam logic [RegIdxW-1:0] RegDerivGain     = 3'd2;
  localparam logic [RegIdxW-1:0] RegBaseSpeed     = 3'd3;
  localparam logic [RegIdxW-1:0] RegSpeedLimit    = 3'd4;
  localparam logic [RegIdxW-1:0] RegSpinSpeed     = 3'd5;

  typedef struct packed {
    logic [7:0]  line_mask;
    logic [15:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [7:0]         mask_echo;
    logic signed [15:0] steer_error;
    logic               line_lost;
    logic signed [15:0] left_wheel;
    logic signed [15:0] right_wheel;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] numer;
    logic [DivDenW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

@@ hdl/lfps_div.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lfps_div import lfps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivNumW);
  localparam logic [CntW-1:0] LastIter = CntW'(DivNumW - 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivNumW-1:0] quo_q;

  logic [DivDenW:0]   trial;
  logic               fits;
  logic [DivDenW-1:0] rem_d;

  // The numerator shifts out of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    fits  = trial >= {1'b0, den_q};
    if (fits) begin
      rem_d = DivDenW'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[DivDenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.numer;
      den_q <= req_i.denom;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivNumW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ hdl/line_follow_pd_steering.sv @@
// Top level of the line follower PD steering block: sequencer, shared multiplier, registers.
`timescale 1ns / 1ps
`include "line_follow_pd_steering_macros.svh"

// Usage: an input transaction carries one sensor mask and the milliseconds since the
// previous frame; each input transaction yields exactly one output transaction with the
// echoed mask, the steering error, the lost flag and both wheel speeds.
// One item is worked on at a time, so in_stall_o is high from the cycle after acceptance
// until the result has been placed in the output register.
// The sensor sum walks the sensors one per cycle; an empty mask then goes straight to the
// wheel stage, else the error and, unless skipped, the derivative are divided in the shared
// radix-2 divider before the gain products, the correction sum and the wheel speeds.
// A finished result waits in the output register while out_stall_i is high; a new item
// can be accepted meanwhile, but its result is held back until the register is free.
// Reset clears the configuration registers, the error history and the output valid flag.
// Registers sit at byte address 8*i on the 64-bit APB port; every write to a defined
// register clears the error history. The user must make writes only while the block is
// idle; the block itself does not enforce this.
module line_follow_pd_steering import lfps_pkg::*; #(
  parameter int SensorCount = SensorCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int CntW = (SensorCount > 1) ? $clog2(SensorCount) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(SensorCount - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ACC   = 12'b0000_0000_0010,
    S_ECHK  = 12'b0000_0000_0100,
    S_EDIV  = 12'b0000_0000_1000,
    S_DPREP = 12'b0000_0001_0000,
    S_DMUL  = 12'b0000_0010_0000,
    S_DDIVS = 12'b0000_0100_0000,
    S_DDIV  = 12'b0000_1000_0000,
    S_PMUL  = 12'b0001_0000_0000,
    S_KMUL  = 12'b0010_0000_0000,
    S_CSUM  = 12'b0100_0000_0000,
    S_WHEEL = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [63:0]        weights_q;
  logic signed [15:0] kp_q;
  logic signed [15:0] kd_q;
  logic [14:0]        base_q;
  logic [14:0]        limit_q;
  logic [14:0]        spin_q;

  // Error history.
  logic signed [15:0] prev_err_q;
  logic               prev_valid_q;

  // Working registers of the current item.
  logic [7:0]           mask_q;
  logic [15:0]          ms_q;
  logic [7:0]           mask_sh_q;
  logic [63:0]          w_sh_q;
  logic [CntW-1:0]      idx_q;
  logic signed [SumW-1:0] sum_q;
  logic [CountW-1:0]    count_q;
  logic                 neg_q;
  logic signed [15:0]   err_q;
  logic signed [15:0]   deriv_q;
  logic signed [33:0]   prod_q;
  logic signed [33:0]   acc_q;
  logic signed [15:0]   corr_q;

  logic out_valid_q;
  out_t out_q;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;
  logic               cfg_hit;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod_d;
  logic signed [16:0] diff;
  logic [SumW-1:0]    sum_mag;
  logic [33:0]        prod_mag;
  logic [15:0]        quot_lo;
  logic signed [34:0] corr_sum;
  logic signed [26:0] corr_shr;
  logic signed [17:0] left_raw;
  logic signed [17:0] right_raw;
  logic signed [15:0] left_clamp;
  logic signed [15:0] right_clamp;
  logic               lost;
  logic               spin_pos;
  logic               out_free;
  logic               load_out;
  out_t               res_d;

  // ---------------------------------------------------------------- APB port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (cfg_idx == RegSensorWeights || cfg_idx == RegPropGain ||
                              cfg_idx == RegDerivGain || cfg_idx == RegBaseSpeed ||
                              cfg_idx == RegSpeedLimit || cfg_idx == RegSpinSpeed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= '0;
      kp_q      <= '0;
      kd_q      <= '0;
      base_q    <= '0;
      limit_q   <= '0;
      spin_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegSensorWeights: weights_q <= pwdata;
        RegPropGain:      kp_q      <= pwdata[15:0];
        RegDerivGain:     kd_q      <= pwdata[15:0];
        RegBaseSpeed:     base_q    <= pwdata[14:0];
        RegSpeedLimit:    limit_q   <= pwdata[14:0];
        RegSpinSpeed:     spin_q    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegSensorWeights: prdata = weights_q;
      RegPropGain:      prdata = {48'd0, kp_q};
      RegDerivGain:     prdata = {48'd0, kd_q};
      RegBaseSpeed:     prdata = {49'd0, base_q};
      RegSpeedLimit:    prdata = {49'd0, limit_q};
      RegSpinSpeed:     prdata = {49'd0, spin_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- Shared units
  lfps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign diff = {err_q[15], err_q} - {prev_err_q[15], prev_err_q};

  always_comb begin
    case (state_q)
      S_DMUL: begin
        mul_a = diff;
        mul_b = 17'sd1000;
      end
      S_PMUL: begin
        mul_a = {kp_q[15], kp_q};
        mul_b = {err_q[15], err_q};
      end
      S_KMUL: begin
        mul_a = {kd_q[15], kd_q};
        mul_b = {deriv_q[15], deriv_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign prod_mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
  assign quot_lo  = div_rsp.quot[15:0];

  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = '0;
    div_req.denom = '0;
    case (state_q)
      S_ECHK: begin
        div_req.start = (mask_q != 8'd0) && (count_q != '0);
        div_req.numer = DivNumW'({sum_mag, 4'b0000});
        div_req.denom = DivDenW'(count_q);
      end
      S_DDIVS: begin
        div_req.start = 1'b1;
        div_req.numer = prod_mag[DivNumW-1:0];
        div_req.denom = ms_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- Correction and wheels
  assign corr_sum = 35'(acc_q) + 35'(prod_q);
  assign corr_shr = 27'(corr_sum >>> 8);

  assign left_raw  = $signed({3'b000, base_q}) + 18'(corr_q);
  assign right_raw = $signed({3'b000, base_q}) - 18'(corr_q);

  always_comb begin
    if (left_raw < 0) begin
      left_clamp = '0;
    end else if (left_raw > $signed({3'b000, limit_q})) begin
      left_clamp = {1'b0, limit_q};
    end else begin
      left_clamp = left_raw[15:0];
    end
    if (right_raw < 0) begin
      right_clamp = '0;
    end else if (right_raw > $signed({3'b000, limit_q})) begin
      right_clamp = {1'b0, limit_q};
    end else begin
      right_clamp = right_raw[15:0];
    end
  end

  assign lost     = (mask_q == 8'd0);
  assign spin_pos = !prev_valid_q || !prev_err_q[15];

  always_comb begin
    if (lost) begin
      res_d.mask_echo   = 8'd0;
      res_d.steer_error = prev_err_q;
      res_d.line_lost   = 1'b1;
      res_d.left_wheel  = spin_pos ? $signed({1'b0, spin_q}) : -$signed({1'b0, spin_q});
      res_d.right_wheel = spin_pos ? -$signed({1'b0, spin_q}) : $signed({1'b0, spin_q});
    end else begin
      res_d.mask_echo   = mask_q;
      res_d.steer_error = err_q;
      res_d.line_lost   = 1'b0;
      res_d.left_wheel  = left_clamp;
      res_d.right_wheel = right_clamp;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_WHEEL) && out_free;

  // ---------------------------------------------------------------- Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ACC;
      S_ACC:   if (idx_q == LastIdx) state_d = S_ECHK;
      S_ECHK: begin
        if (lost) begin
          state_d = S_WHEEL;
        end else if (count_q == '0) begin
          state_d = S_DPREP;
        end else begin
          state_d = S_EDIV;
        end
      end
      S_EDIV:  if (div_rsp.done) state_d = S_DPREP;
      S_DPREP: state_d = (prev_valid_q && ms_q != 16'd0) ? S_DMUL : S_PMUL;
      S_DMUL:  state_d = S_DDIVS;
      S_DDIVS: state_d = S_DDIV;
      S_DDIV:  if (div_rsp.done) state_d = S_PMUL;
      S_PMUL:  state_d = S_KMUL;
      S_KMUL:  state_d = S_CSUM;
      S_CSUM:  state_d = S_WHEEL;
      S_WHEEL: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_err_q   <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        prev_err_q   <= '0;
        prev_valid_q <= 1'b0;
      end else if (load_out && !lost) begin
        prev_err_q   <= err_q;
        prev_valid_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        mask_q    <= in_data_i.line_mask;
        ms_q      <= in_data_i.elapsed_ms;
        mask_sh_q <= in_data_i.line_mask;
        w_sh_q    <= weights_q;
        idx_q     <= '0;
        sum_q     <= '0;
        count_q   <= '0;
      end
      S_ACC: begin
        if (mask_sh_q[0]) begin
          sum_q   <= sum_q + {{(SumW-WeightW){w_sh_q[WeightW-1]}}, w_sh_q[WeightW-1:0]};
          count_q <= count_q + 1'b1;
        end
        mask_sh_q <= {1'b0, mask_sh_q[7:1]};
        w_sh_q    <= {8'd0, w_sh_q[63:8]};
        idx_q     <= idx_q + 1'b1;
      end
      S_ECHK: begin
        neg_q <= sum_q[SumW-1];
        if (count_q == '0) begin
          err_q <= '0;
        end
      end
      S_EDIV: begin
        if (div_rsp.done) begin
          err_q <= neg_q ? -$signed(quot_lo) : $signed(quot_lo);
        end
      end
      S_DPREP: begin
        deriv_q <= '0;
      end
      S_DDIVS: begin
        neg_q <= prod_q[33];
      end
      S_DDIV: begin
        if (div_rsp.done) begin
          if (neg_q) begin
            deriv_q <= (div_rsp.quot > DivNumW'(32768)) ? 16'sh8000 : -$signed(quot_lo);
          end else begin
            deriv_q <= (div_rsp.quot > DivNumW'(32767)) ? 16'sh7fff : $signed(quot_lo);
          end
        end
      end
      S_KMUL: begin
        acc_q <= prod_q;
      end
      S_CSUM: begin
        if (corr_shr > 27'sd32767) begin
          corr_q <= 16'sh7fff;
        end else if (corr_shr < -27'sd32768) begin
          corr_q <= 16'sh8000;
        end else begin
          corr_q <= corr_shr[15:0];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q <= res_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- Assertions
  `LFPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                    "block not busy after accepting an item")
  `LFPS_ASSERT_IMP(a_lost_mask_zero, out_valid_o && out_data_o.line_lost,
                   out_data_o.mask_echo == 8'd0, "lost result with nonzero mask echo")
  `LFPS_ASSERT_IMP(a_wheels_clamped, out_valid_o && !out_data_o.line_lost,
                   !out_data_o.left_wheel[15] && !out_data_o.right_wheel[15],
                   "negative wheel speed on the normal path")
  `LFPS_ASSERT_IMP(a_div_done_in_wait, div_rsp.done,
                   state_q == S_EDIV || state_q == S_DDIV,
                   "divider finished outside a wait state")

endmodule

@@ tb/line_follow_pd_steering_test.sv @@
// Self-checking testbench for the line follower PD steering block.
`timescale 1ns / 1ps

module line_follow_pd_steering_test;
  import lfps_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int TailCycles = 80;

  // Index past the last defined register; a write there must leave the history alone.
  localparam logic [RegIdxW-1:0] RegSpare = 3'd6;

  typedef enum bit {RowItem, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   value;
    in_t                item;
    bit                 known;
    out_t               want;
  } step_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Shadow copy of the register file and the error history.
  logic [63:0]        weights_r;
  logic signed [15:0] prop_gain_r;
  logic signed [15:0] deriv_gain_r;
  logic [14:0]        base_r;
  logic [14:0]        limit_r;
  logic [14:0]        spin_r;
  logic signed [15:0] last_err;
  logic               last_err_ok;

  out_t      pending_steer_q[$];
  step_row_t plan_q[$];
  int        mismatch_cnt = 0;
  int        result_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_req = 0;
  bit        no_idle = 1'b0;

  line_follow_pd_steering DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t ERROR result %0d: %s", $time, result_cnt, msg);
    mismatch_cnt++;
  endtask

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int clamp_wheel(int s);
    if (s < 0) return 0;
    if (s > int'(limit_r)) return int'(limit_r);
    return s;
  endfunction

  // Computes the steering result of one frame and advances the error history when the line is seen.
  function automatic out_t predict_steering(in_t item);
    out_t               r;
    int                 sum;
    int                 cnt;
    int                 err;
    int                 deriv;
    int                 corr;
    longint             acc;
    logic signed [7:0]  w;
    r.mask_echo = item.line_mask;
    r.line_lost = 1'b0;
    if (item.line_mask == 8'h00) begin
      r.mask_echo   = 8'h00;
      r.line_lost   = 1'b1;
      r.steer_error = last_err;
      // The search spins toward the side where the line was last seen.
      if (!last_err_ok || last_err >= 0) begin
        r.left_wheel  = 16'(int'(spin_r));
        r.right_wheel = 16'(-int'(spin_r));
      end else begin
        r.left_wheel  = 16'(-int'(spin_r));
        r.right_wheel = 16'(int'(spin_r));
      end
      return r;
    end
    sum = 0;
    cnt = 0;
    for (int i = 0; i < SensorCountDef; i++) begin
      if (item.line_mask[i]) begin
        w = weights_r[8*i +: 8];
        sum += w;
        cnt++;
      end
    end
    err = (cnt == 0) ? 0 : (sum * 16) / cnt;
    deriv = 0;
    if (last_err_ok && item.elapsed_ms != 16'h0000) begin
      acc   = (longint'(err) - longint'(last_err)) * 1000;
      deriv = sat16(acc / longint'(item.elapsed_ms));
    end
    acc  = longint'(prop_gain_r) * err + longint'(deriv_gain_r) * deriv;
    corr = sat16(acc >>> 8);
    r.steer_error = 16'(err);
    r.left_wheel  = 16'(clamp_wheel(int'(base_r) + corr));
    r.right_wheel = 16'(clamp_wheel(int'(base_r) - corr));
    last_err    = 16'(err);
    last_err_ok = 1'b1;
    return r;
  endfunction

  function automatic step_row_t item_row(logic [7:0] mask, logic [15:0] ms);
    step_row_t row;
    row.kind  = RowItem;
    row.idx   = '0;
    row.value = '0;
    row.item  = '{line_mask: mask, elapsed_ms: ms};
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic step_row_t known_row(logic [7:0] mask, logic [15:0] ms, out_t want);
    step_row_t row;
    row       = item_row(mask, ms);
    row.known = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic step_row_t write_row(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
    step_row_t row;
    row       = item_row(8'h00, 16'h0000);
    row.kind  = RowWrite;
    row.idx   = idx;
    row.value = value;
    return row;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic logic [14:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return 15'h0000;
      1: return 15'h7FFF;
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic reg_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSensorWeights: weights_r    = value;
      RegPropGain:      prop_gain_r  = value[15:0];
      RegDerivGain:     deriv_gain_r = value[15:0];
      RegBaseSpeed:     base_r       = value[14:0];
      RegSpeedLimit:    limit_r      = value[14:0];
      RegSpinSpeed:     spin_r       = value[14:0];
      default: ;
    endcase
    if (idx <= RegSpinSpeed) begin
      last_err    = '0;
      last_err_ok = 1'b0;
    end
  endtask

  task automatic send_item(in_t item, bit known, out_t want);
    int   gap;
    out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_steering(item);
    pending_steer_q.push_back(known ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_steer_q.size() != 0) @(posedge clk_i);
  endtask

  // Output side: random stalls per transaction, plus an occasional long hold-off.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_steer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result with mask_echo %h",
                                  out_data_o.mask_echo));
      end else begin
        want = pending_steer_q.pop_front();
        if (out_data_o.mask_echo !== want.mask_echo)
          report_mismatch($sformatf("mask_echo got %h want %h",
                                    out_data_o.mask_echo, want.mask_echo));
        if (out_data_o.steer_error !== want.steer_error)
          report_mismatch($sformatf("steer_error got %0d want %0d",
                                    out_data_o.steer_error, want.steer_error));
        if (out_data_o.line_lost !== want.line_lost)
          report_mismatch($sformatf("line_lost got %b want %b",
                                    out_data_o.line_lost, want.line_lost));
        if (out_data_o.left_wheel !== want.left_wheel)
          report_mismatch($sformatf("left_wheel got %0d want %0d",
                                    out_data_o.left_wheel, want.left_wheel));
        if (out_data_o.right_wheel !== want.right_wheel)
          report_mismatch($sformatf("right_wheel got %0d want %0d",
                                    out_data_o.right_wheel, want.right_wheel));
      end
      result_cnt++;
    end
  end

  initial begin
    in_t item;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    weights_r    = '0;
    prop_gain_r  = '0;
    deriv_gain_r = '0;
    base_r       = '0;
    limit_r      = '0;
    spin_r       = '0;
    last_err     = '0;
    last_err_ok  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan_q = '{
      // Everything is zero after reset.
      known_row(8'h00, 16'h0000, out_t'{8'h00, 16'sd0, 1'b1, 16'sd0, 16'sd0}),
      known_row(8'hFF, 16'hFFFF, out_t'{8'hFF, 16'sd0, 1'b0, 16'sd0, 16'sd0}),
      // Largest positive weights, full speed without any gain.
      write_row(RegSensorWeights, 64'h7F7F_7F7F_7F7F_7F7F),
      write_row(RegBaseSpeed, 64'h7FFF),
      write_row(RegSpeedLimit, 64'h7FFF),
      known_row(8'hFF, 16'h0001, out_t'{8'hFF, 16'sd2032, 1'b0, 16'sd32767, 16'sd32767}),
      known_row(8'h80, 16'hFFFF, out_t'{8'h80, 16'sd2032, 1'b0, 16'sd32767, 16'sd32767}),
      // Most negative weights; a lost line then reports the last error.
      write_row(RegSensorWeights, 64'h8080_8080_8080_8080),
      known_row(8'h01, 16'h0000, out_t'{8'h01, -16'sd2048, 1'b0, 16'sd32767, 16'sd32767}),
      known_row(8'h00, 16'h0005, out_t'{8'h00, -16'sd2048, 1'b1, 16'sd0, 16'sd0}),
      // A spread of positions with moderate gains.
      write_row(RegSensorWeights, 64'h3020_1008_F8F0_E0D0),
      write_row(RegPropGain, 64'h0200),
      write_row(RegDerivGain, 64'h0010),
      write_row(RegBaseSpeed, 64'h0800),
      write_row(RegSpeedLimit, 64'h1000),
      write_row(RegSpinSpeed, 64'h0300),
      item_row(8'h18, 16'd10),
      item_row(8'h01, 16'd10),
      item_row(8'h00, 16'd7),
      item_row(8'h80, 16'd0),
      item_row(8'h00, 16'd3),
      item_row(8'hC0, 16'hFFFF),
      item_row(8'h3C, 16'd1),
      item_row(8'hAA, 16'd250),
      // Gain extremes drive both the derivative and the correction into saturation.
      write_row(RegPropGain, 64'h8000),
      write_row(RegDerivGain, 64'h7FFF),
      item_row(8'h01, 16'd1),
      item_row(8'h80, 16'd1),
      item_row(8'h80, 16'd3),
      write_row(RegPropGain, 64'h7FFF),
      write_row(RegDerivGain, 64'h8000),
      write_row(RegBaseSpeed, 64'h0000),
      write_row(RegSpinSpeed, 64'h7FFF),
      item_row(8'h01, 16'd2),
      item_row(8'h00, 16'd9),
      item_row(8'hFF, 16'hFFFF),
      // The derivative after this write must still see the previous error.
      write_row(RegSpare, 64'hFFFF_FFFF_FFFF_FFFF),
      item_row(8'h80, 16'd1),
      item_row(8'h00, 16'd0)
    };

    foreach (plan_q[k]) begin
      if (plan_q[k].kind == RowWrite) begin
        drain_results();
        reg_write(plan_q[k].idx, plan_q[k].value);
      end else begin
        send_item(plan_q[k].item, plan_q[k].known, plan_q[k].want);
      end
    end

    for (int phase = 0; phase < 10; phase++) begin
      drain_results();
      no_idle = (phase % 4 == 3);
      case (phase)
        2: reg_write(RegSensorWeights, 64'h8080_8080_8080_8080);
        8: reg_write(RegSensorWeights, 64'h7F7F_7F7F_7F7F_7F7F);
        default: reg_write(RegSensorWeights, {$urandom, $urandom});
      endcase
      reg_write(RegPropGain, 64'(pick_gain()));
      reg_write(RegDerivGain, 64'(pick_gain()));
      reg_write(RegBaseSpeed, 64'(pick_speed()));
      reg_write(RegSpeedLimit, 64'(pick_speed()));
      reg_write(RegSpinSpeed, 64'(pick_speed()));
      if (phase == 5) reg_write(RegSpare, {$urandom, $urandom});
      // Hold the output long enough that the block backs up onto its input.
      if (phase == 1) hold_req = 400;
      if (phase == 6) hold_req = 250;
      for (int k = 0; k < 95; k++) begin
        case ($urandom_range(0, 7))
          0: item.line_mask = 8'h00;
          1: item.line_mask = 8'h01 << $urandom_range(0, 7);
          default: item.line_mask = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 7))
          0: item.elapsed_ms = 16'h0000;
          1: item.elapsed_ms = 16'hFFFF;
          2: item.elapsed_ms = 16'($urandom);
          default: item.elapsed_ms = 16'($urandom_range(1, 50));
        endcase
        send_item(item, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_steer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_steer_q.size()));
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
